// File: sv/smp_pkg.sv
// Shared types and constants for the symbolic mode parser.
package smp_pkg;

   localparam int MAX_LENGTH = 255;
   localparam int CNT_W      = $clog2(MAX_LENGTH + 1);
   localparam int MODE_W     = 12;
   localparam int CHAR_W     = 8;
   localparam int POS_W      = 8;

   localparam logic [MODE_W-1:0] UMASK_RESET = 12'o0022;

   localparam logic [MODE_W-1:0] S_IRWXU = 12'o0700;
   localparam logic [MODE_W-1:0] S_IRWXG = 12'o0070;
   localparam logic [MODE_W-1:0] S_IRWXO = 12'o0007;
   localparam logic [MODE_W-1:0] S_IRWXA = 12'o0777;
   localparam logic [MODE_W-1:0] S_IXALL = 12'o0111;
   localparam logic [MODE_W-1:0] S_IRALL = 12'o0444;
   localparam logic [MODE_W-1:0] S_IWALL = 12'o0222;
   localparam logic [MODE_W-1:0] S_ISUID = 12'o4000;
   localparam logic [MODE_W-1:0] S_ISGID = 12'o2000;
   localparam logic [MODE_W-1:0] S_ISVTX = 12'o1000;

   localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_EQUAL = 8'h3D;
   localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
   localparam logic [CHAR_W-1:0] CH_UPX   = 8'h58;
   localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
   localparam logic [CHAR_W-1:0] CH_G     = 8'h67;
   localparam logic [CHAR_W-1:0] CH_O     = 8'h6F;
   localparam logic [CHAR_W-1:0] CH_R     = 8'h72;
   localparam logic [CHAR_W-1:0] CH_S     = 8'h73;
   localparam logic [CHAR_W-1:0] CH_T     = 8'h74;
   localparam logic [CHAR_W-1:0] CH_U     = 8'h75;
   localparam logic [CHAR_W-1:0] CH_W     = 8'h77;
   localparam logic [CHAR_W-1:0] CH_X     = 8'h78;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_SET = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      PH_WHO   = 3'd0,
      PH_OP    = 3'd1,
      PH_PERMS = 3'd2,
      PH_AFTER = 3'd3,
      PH_DONE  = 3'd4
   } phase_type;

   typedef struct packed {
      logic [MODE_W-1:0] original_mode;
      logic [MODE_W-1:0] working_mode;
      logic [MODE_W-1:0] who_bits;
      logic [MODE_W-1:0] perm_bits;
      op_type            pending_op;
      phase_type         phase;
      logic              halted;
      logic              directory_flag;
      logic [CNT_W-1:0]  consumed_count;
   } state_type;

   typedef struct packed {
      logic [MODE_W-1:0] final_mode;
      logic [POS_W-1:0]  stop_position;
      logic              complete;
   } result_type;

endpackage

// File: sv/symbolic_mode_parser.sv
// Top level of the symbolic permission mode parser.
// A NUL word gives its result word on rsp_* in the cycle after its acceptance.
// Throughput: one character word per cycle while req_ready is high; the combinational next-state update sets it.
// req_ready drops only while a result word waits and rsp_ready is low.
// Reset: synchronous, active high; clears parser state, sets umask to 0022.
// A result word is produced only for a NUL character.
module symbolic_mode_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_first,
   input  logic [smp_pkg::CHAR_W-1:0]    req_character,
   input  logic [smp_pkg::MODE_W-1:0]    req_initial_mode,
   input  logic                          req_is_directory,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [smp_pkg::MODE_W-1:0]    rsp_final_mode,
   output logic [smp_pkg::POS_W-1:0]     rsp_stop_position,
   output logic                          rsp_complete,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [smp_pkg::MODE_W-1:0]    csr_umask_bits
);
   import smp_pkg::*;

   state_type         state_ff;
   state_type         state_in;
   result_type        step_res;
   logic              step_emit;
   logic [MODE_W-1:0] umask_ff;
   logic              rsp_valid_ff;
   result_type        rsp_ff;
   logic              req_take;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   smp_step u_step (
      .cur          (state_ff),
      .first        (req_first),
      .character    (req_character),
      .initial_mode (req_initial_mode),
      .is_directory (req_is_directory),
      .umask_bits   (umask_ff),
      .nxt          (state_in),
      .res          (step_res),
      .emit         (step_emit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{original_mode: '0, working_mode: '0, who_bits: '0, perm_bits: '0,
                       pending_op: OP_ADD, phase: PH_WHO, halted: 1'b0,
                       directory_flag: 1'b0, consumed_count: '0};
         umask_ff     <= UMASK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) umask_ff <= csr_umask_bits;
         if (req_take) begin
            state_ff     <= state_in;
            rsp_valid_ff <= step_emit;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && step_emit) rsp_ff <= step_res;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_final_mode    = rsp_ff.final_mode;
   assign rsp_stop_position = rsp_ff.stop_position;
   assign rsp_complete      = rsp_ff.complete;

`ifndef ASSERT_OFF
   a_no_rsp_on_char : assert property (@(posedge clock) disable iff (reset)
      req_take && (req_character != CH_NUL) |=> !rsp_valid)
      else $error("result word raised by a non-NUL character");

   a_rsp_on_nul : assert property (@(posedge clock) disable iff (reset)
      req_take && (req_character == CH_NUL) |=> rsp_valid)
      else $error("NUL character gave no result word");

   a_empty_expr : assert property (@(posedge clock) disable iff (reset)
      req_take && req_first && (req_character == CH_NUL) |=>
         rsp_complete && (rsp_stop_position == '0) &&
         (rsp_final_mode == $past(req_initial_mode)))
      else $error("empty expression changed the mode");

   a_halt_sticky : assert property (@(posedge clock) disable iff (reset)
      state_ff.halted && !(req_take && req_first) |=> state_ff.halted)
      else $error("halt cleared without a new expression");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      state_ff.consumed_count <= CNT_W'(MAX_LENGTH))
      else $error("consumed count beyond limit");
`endif

endmodule

// File: sv/smp_step.sv
// Next-state and result logic for one expression character.
module smp_step (
   input  smp_pkg::state_type            cur,
   input  logic                          first,
   input  logic [smp_pkg::CHAR_W-1:0]    character,
   input  logic [smp_pkg::MODE_W-1:0]    initial_mode,
   input  logic                          is_directory,
   input  logic [smp_pkg::MODE_W-1:0]    umask_bits,
   output smp_pkg::state_type            nxt,
   output smp_pkg::result_type           res,
   output logic                          emit
);
   import smp_pkg::*;

   function automatic logic is_copy(input logic [CHAR_W-1:0] c);
      return (c == CH_U) || (c == CH_G) || (c == CH_O);
   endfunction

   function automatic logic is_who(input logic [CHAR_W-1:0] c);
      return is_copy(c) || (c == CH_A);
   endfunction

   function automatic logic is_op(input logic [CHAR_W-1:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_EQUAL);
   endfunction

   function automatic logic is_perm(input logic [CHAR_W-1:0] c);
      return (c == CH_R) || (c == CH_W) || (c == CH_X) || (c == CH_UPX) ||
             (c == CH_S) || (c == CH_T);
   endfunction

   function automatic logic [MODE_W-1:0] who_mask(input logic [CHAR_W-1:0] c);
      logic [MODE_W-1:0] m;
      priority if (c == CH_U) m = S_IRWXU | S_ISUID;
      else if (c == CH_G)     m = S_IRWXG | S_ISGID;
      else if (c == CH_O)     m = S_IRWXO;
      else                    m = S_IRWXA | S_ISUID | S_ISGID;
      return m;
   endfunction

   function automatic logic [MODE_W-1:0] copy_mask(input logic [CHAR_W-1:0] c,
                                                   input logic [MODE_W-1:0] src);
      logic [MODE_W-1:0] m;
      logic [MODE_W-1:0] r;
      priority if (c == CH_U) begin
         m = src & S_IRWXU;
         r = m | (m >> 3) | (m >> 6);
      end else if (c == CH_G) begin
         m = src & S_IRWXG;
         r = m | (m << 3) | (m >> 3);
      end else begin
         m = src & S_IRWXO;
         r = m | (m << 3) | (m << 6);
      end
      return r;
   endfunction

   function automatic logic [MODE_W-1:0] perm_mask(input logic [CHAR_W-1:0] c,
                                                   input logic dir,
                                                   input logic [MODE_W-1:0] orig);
      logic [MODE_W-1:0] m;
      priority if (c == CH_R) m = S_IRALL;
      else if (c == CH_W)     m = S_IWALL;
      else if (c == CH_X)     m = S_IXALL;
      else if (c == CH_UPX)   m = (dir || ((orig & S_IXALL) != '0)) ? S_IXALL : '0;
      else if (c == CH_S)     m = S_ISUID | S_ISGID;
      else                    m = S_ISVTX;
      return m;
   endfunction

   function automatic logic [CNT_W-1:0] consume(input logic [CNT_W-1:0] cnt);
      return (cnt < CNT_W'(MAX_LENGTH)) ? cnt + CNT_W'(1) : cnt;
   endfunction

   function automatic state_type apply_pending(input state_type s_in,
                                               input logic [MODE_W-1:0] umask);
      state_type         s;
      logic [MODE_W-1:0] m;
      s = s_in;
      if (s.perm_bits != '0) begin
         if (s.who_bits == '0) s.who_bits = ~umask;
         m = s.who_bits & s.perm_bits;
         unique case (s.pending_op)
            OP_ADD:  s.working_mode = s.working_mode | m;
            OP_SUB:  s.working_mode = s.working_mode & ~m;
            default: s.working_mode = (s.working_mode & ~(s.who_bits & S_IRWXA)) | m;
         endcase
      end
      s.perm_bits = '0;
      return s;
   endfunction

   function automatic state_type start_op(input state_type s_in,
                                          input logic [CHAR_W-1:0] c);
      state_type s;
      s = s_in;
      priority if (c == CH_PLUS) s.pending_op = OP_ADD;
      else if (c == CH_MINUS)    s.pending_op = OP_SUB;
      else                       s.pending_op = OP_SET;
      s.perm_bits      = '0;
      s.consumed_count = consume(s.consumed_count);
      s.phase          = PH_OP;
      return s;
   endfunction

   function automatic state_type start_clause(input state_type s_in);
      state_type s;
      s = s_in;
      s.who_bits       = '0;
      s.consumed_count = consume(s.consumed_count);
      s.phase          = PH_WHO;
      return s;
   endfunction

   state_type s;

   always_comb begin
      s = cur;
      if (first) begin
         s.original_mode  = initial_mode;
         s.working_mode   = initial_mode;
         s.directory_flag = is_directory;
         s.who_bits       = '0;
         s.perm_bits      = '0;
         s.pending_op     = OP_ADD;
         s.phase          = PH_WHO;
         s.halted         = 1'b0;
         s.consumed_count = '0;
      end
      emit = 1'b0;
      if (character == CH_NUL) begin
         if (!s.halted && s.phase == PH_PERMS) s = apply_pending(s, umask_bits);
         s.phase = PH_DONE;
         emit    = 1'b1;
      end else if (!s.halted) begin
         unique case (s.phase)
            PH_WHO: begin
               priority if (is_who(character)) begin
                  s.who_bits       = s.who_bits | who_mask(character);
                  s.consumed_count = consume(s.consumed_count);
               end else if (is_op(character)) begin
                  s = start_op(s, character);
               end else begin
                  s.halted = 1'b1;
               end
            end
            PH_OP: begin
               priority if (is_copy(character)) begin
                  s.perm_bits      = copy_mask(character, s.working_mode);
                  s                = apply_pending(s, umask_bits);
                  s.consumed_count = consume(s.consumed_count);
                  s.phase          = PH_AFTER;
               end else if (is_perm(character)) begin
                  s.perm_bits      = perm_mask(character, s.directory_flag,
                                               s.original_mode);
                  s.consumed_count = consume(s.consumed_count);
                  s.phase          = PH_PERMS;
               end else if (character == CH_COMMA) begin
                  s = start_clause(s);
               end else begin
                  s.halted = 1'b1;
               end
            end
            PH_PERMS, PH_AFTER: begin
               if (s.phase == PH_PERMS && is_perm(character)) begin
                  s.perm_bits      = s.perm_bits | perm_mask(character, s.directory_flag,
                                                             s.original_mode);
                  s.consumed_count = consume(s.consumed_count);
               end else begin
                  if (s.phase == PH_PERMS) begin
                     s       = apply_pending(s, umask_bits);
                     s.phase = PH_AFTER;
                  end
                  priority if (is_op(character)) s = start_op(s, character);
                  else if (character == CH_COMMA) s = start_clause(s);
                  else s.halted = 1'b1;
               end
            end
            default: ;
         endcase
      end
      nxt               = s;
      res.final_mode    = s.working_mode;
      res.stop_position = (s.consumed_count > CNT_W'(255)) ? POS_W'(255)
                                                           : POS_W'(s.consumed_count);
      res.complete      = !s.halted;
   end

endmodule
